FILE: rtl/ufr_pkg.sv
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and constants of the disjoint-set store with undo history.
// ----------------------------------------------------------------------------
package ufr_pkg;

	localparam int UFR_NODES   = 1024;
	localparam int UFR_IDX_W   = 10;
	localparam int UFR_DEPTH_W = 10;
	localparam int UFR_PROD_W  = 21;

	typedef enum logic [1:0] {
		ACT_UNITE    = 2'd0,
		ACT_ROLLBACK = 2'd1,
		ACT_QUERY    = 2'd2
	} ufr_action_t;

	typedef enum logic [1:0] {
		ST_MERGED   = 2'd0,
		ST_SAME     = 2'd1,
		ST_ROLLED   = 2'd2,
		ST_NOTHING  = 2'd3
	} ufr_status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_RED1,
		S_RED2,
		S_FA_RD,
		S_FA_CHK,
		S_FB_RD,
		S_FB_CHK,
		S_SZ_RD,
		S_SZ_A,
		S_SZ_B,
		S_PROD,
		S_MERGE,
		S_RB_RD,
		S_RB_HD,
		S_RB_SK,
		S_RB_SH,
		S_RB_WR,
		S_DONE
	} ufr_state_t;

	typedef struct packed {
		logic [1:0]             action;
		logic [UFR_IDX_W-1:0]   node_a;
		logic [UFR_IDX_W-1:0]   node_b;
		logic [UFR_DEPTH_W-1:0] target_depth;
	} ufr_req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [UFR_PROD_W-1:0]  size_product;
		logic [UFR_DEPTH_W-1:0] history_depth;
	} ufr_rsp_t;

endpackage

FILE: rtl/ufr_ram.sv
// ----------------------------------------------------------------------------
// ufr_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ufr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/union_find_with_rollback.sv
// ----------------------------------------------------------------------------
// union_find_with_rollback
// Disjoint-set store, union by size, no path compression, with undo history.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one beat per action (unite, roll back, size product query).
//   rsp channel: exactly one beat for every request beat, in order.
//   After reset the block sweeps the parent and size memories, one entry a
//   cycle, over all NODES entries; req_stall stays high during that sweep.
//   Per request: take the beat, reduce the indexes and dispatch; for a
//   unite or query walk from node_a, then from node_b, to its root, read both
//   sizes and merge or form the product (a unite within one set skips the
//   size reads and merge); a roll back runs S_RB_RD to S_RB_WR per undone
//   union, none when there is nothing to undo; then the response register
//   loads. Find walks follow one link per cycle on the single parent read port.
//   One request is worked at a time; the next one is taken once the result
//   sits in the response register, even while rsp_stall holds it there.
//   While rsp_stall is high and a result is already waiting, a finished
//   request holds in its last state until the register frees up.
// ----------------------------------------------------------------------------
module union_find_with_rollback #(
	parameter int NODES = ufr_pkg::UFR_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ufr_pkg::ufr_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ufr_pkg::ufr_rsp_t rsp
);

	import ufr_pkg::*;

	localparam int NW   = $clog2(NODES);
	localparam int SW   = $clog2(NODES + 1);
	localparam int HW   = $clog2(NODES);
	localparam int HD   = NODES - 1;
	localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;
	localparam int CW   = (HW > UFR_DEPTH_W) ? HW : UFR_DEPTH_W;
	localparam int PW   = (2 * SW > UFR_PROD_W) ? 2 * SW : UFR_PROD_W;
	localparam logic [20:0] RECIP = 21'((1 << 20) / NODES);

	ufr_state_t state_q, state_d;

	logic [NW-1:0]          clr_q;
	logic [1:0]             act_q;
	logic [UFR_IDX_W-1:0]   a_q, b_q;
	logic [UFR_DEPTH_W-1:0] tgt_q;
	logic [UFR_IDX_W-1:0]   qa_q, qb_q;
	logic [NW-1:0]          idx_a_q, idx_b_q;
	logic [NW-1:0]          cur_q, ra_q, rb_q;
	logic [SW-1:0]          sza_q, szb_q;
	logic [2*SW-1:0]        prod_q;
	logic [HW-1:0]          cnt_q;
	ufr_status_t            st_q;
	logic                   rsp_valid_q;
	ufr_rsp_t               rsp_q;

	logic [30:0]    mul_a, mul_b;
	logic [CW-1:0]  cnt_ext, tgt_ext;
	logic [HW-1:0]  cnt_m1;
	logic           rsp_load;
	logic [NW-1:0]  mg_keep, mg_hung;
	logic [PW-1:0]  prod_ext;

	logic             par_we;
	logic [NW-1:0]    par_waddr, par_wdata, par_raddr, par_rdata;
	logic             sz_we;
	logic [NW-1:0]    sz_waddr, sz_raddr;
	logic [SW-1:0]    sz_wdata, sz_rdata;
	logic             hs_we;
	logic [HAW-1:0]   hs_waddr, hs_raddr;
	logic [2*NW-1:0]  hs_wdata, hs_rdata;

	function automatic logic [NW-1:0] reduce_idx(input logic [UFR_IDX_W-1:0] v,
			input logic [UFR_IDX_W-1:0] q);
		logic [26:0]          qn;
		logic [UFR_IDX_W-1:0] r;
		qn = 27'(q) * 27'(NODES);
		r  = v - qn[UFR_IDX_W-1:0];
		if (32'(r) >= 32'(NODES)) begin
			r = r - UFR_IDX_W'(NODES);
		end
		return NW'(r);
	endfunction

	assign mul_a    = 31'(a_q) * 31'(RECIP);
	assign mul_b    = 31'(b_q) * 31'(RECIP);
	assign cnt_ext  = CW'(cnt_q);
	assign tgt_ext  = CW'(tgt_q);
	assign cnt_m1   = cnt_q - HW'(1);
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign mg_keep  = (szb_q > sza_q) ? rb_q : ra_q;
	assign mg_hung  = (szb_q > sza_q) ? ra_q : rb_q;
	assign prod_ext = PW'(prod_q);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ufr_ram #(.WIDTH(NW), .DEPTH(NODES), .AW(NW)) u_parent (
		.clk   (clk),
		.we    (par_we),
		.waddr (par_waddr),
		.wdata (par_wdata),
		.raddr (par_raddr),
		.rdata (par_rdata)
	);

	ufr_ram #(.WIDTH(SW), .DEPTH(NODES), .AW(NW)) u_size (
		.clk   (clk),
		.we    (sz_we),
		.waddr (sz_waddr),
		.wdata (sz_wdata),
		.raddr (sz_raddr),
		.rdata (sz_rdata)
	);

	ufr_ram #(.WIDTH(2 * NW), .DEPTH(HD), .AW(HAW)) u_history (
		.clk   (clk),
		.we    (hs_we),
		.waddr (hs_waddr),
		.wdata (hs_wdata),
		.raddr (hs_raddr),
		.rdata (hs_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == NW'(NODES - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_RED1;
			end
			S_RED1: state_d = S_RED2;
			S_RED2: begin
				case (act_q)
					ACT_UNITE, ACT_QUERY: state_d = S_FA_RD;
					ACT_ROLLBACK: state_d = (cnt_ext <= tgt_ext) ? S_DONE : S_RB_RD;
					default: state_d = S_DONE;
				endcase
			end
			S_FA_RD: state_d = S_FA_CHK;
			S_FA_CHK: begin
				if (par_rdata == cur_q) state_d = S_FB_RD;
			end
			S_FB_RD: state_d = S_FB_CHK;
			S_FB_CHK: begin
				if (par_rdata == cur_q) begin
					if (act_q == ACT_UNITE && cur_q == ra_q) state_d = S_DONE;
					else state_d = S_SZ_RD;
				end
			end
			S_SZ_RD: state_d = S_SZ_A;
			S_SZ_A:  state_d = S_SZ_B;
			S_SZ_B:  state_d = (act_q == ACT_QUERY) ? S_PROD : S_MERGE;
			S_PROD:  state_d = S_DONE;
			S_MERGE: state_d = S_DONE;
			S_RB_RD: state_d = S_RB_HD;
			S_RB_HD: state_d = S_RB_SK;
			S_RB_SK: state_d = S_RB_SH;
			S_RB_SH: state_d = S_RB_WR;
			S_RB_WR: state_d = (cnt_ext > tgt_ext) ? S_RB_RD : S_DONE;
			S_DONE: begin
				if (rsp_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		par_we    = 1'b0;
		par_waddr = '0;
		par_wdata = '0;
		par_raddr = cur_q;
		sz_we     = 1'b0;
		sz_waddr  = '0;
		sz_wdata  = '0;
		sz_raddr  = ra_q;
		hs_we     = 1'b0;
		hs_waddr  = cnt_q[HAW-1:0];
		hs_wdata  = {mg_keep, mg_hung};
		hs_raddr  = cnt_m1[HAW-1:0];
		case (state_q)
			S_CLEAR: begin
				par_we    = 1'b1;
				par_waddr = clr_q;
				par_wdata = clr_q;
				sz_we     = 1'b1;
				sz_waddr  = clr_q;
				sz_wdata  = SW'(1);
			end
			S_FA_RD:  par_raddr = idx_a_q;
			S_FB_RD:  par_raddr = idx_b_q;
			S_FA_CHK, S_FB_CHK: par_raddr = par_rdata;
			S_SZ_RD:  sz_raddr = ra_q;
			S_SZ_A:   sz_raddr = rb_q;
			S_MERGE: begin
				sz_we     = 1'b1;
				sz_waddr  = mg_keep;
				sz_wdata  = sza_q + szb_q;
				par_we    = 1'b1;
				par_waddr = mg_hung;
				par_wdata = mg_keep;
				hs_we     = 1'b1;
			end
			S_RB_HD:  sz_raddr = hs_rdata[2*NW-1:NW];
			S_RB_SK:  sz_raddr = rb_q;
			S_RB_WR: begin
				sz_we     = 1'b1;
				sz_waddr  = ra_q;
				sz_wdata  = sza_q - szb_q;
				par_we    = 1'b1;
				par_waddr = rb_q;
				par_wdata = rb_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + NW'(1);
			if (state_q == S_MERGE) cnt_q <= cnt_q + HW'(1);
			if (state_q == S_RB_RD) cnt_q <= cnt_m1;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q <= req.action;
				a_q   <= req.node_a;
				b_q   <= req.node_b;
				tgt_q <= req.target_depth;
			end
			S_RED1: begin
				qa_q <= mul_a[29:20];
				qb_q <= mul_b[29:20];
			end
			S_RED2: begin
				idx_a_q <= reduce_idx(a_q, qa_q);
				idx_b_q <= reduce_idx(b_q, qb_q);
				prod_q  <= '0;
				if (act_q == ACT_ROLLBACK) st_q <= (cnt_ext <= tgt_ext) ? ST_NOTHING : ST_ROLLED;
				else st_q <= ST_MERGED;
			end
			S_FA_RD: cur_q <= idx_a_q;
			S_FA_CHK: begin
				if (par_rdata == cur_q) ra_q <= cur_q;
				else cur_q <= par_rdata;
			end
			S_FB_RD: cur_q <= idx_b_q;
			S_FB_CHK: begin
				if (par_rdata == cur_q) begin
					rb_q <= cur_q;
					if (act_q == ACT_UNITE && cur_q == ra_q) st_q <= ST_SAME;
				end else begin
					cur_q <= par_rdata;
				end
			end
			S_SZ_A:  sza_q <= sz_rdata;
			S_SZ_B:  szb_q <= sz_rdata;
			S_PROD:  prod_q <= (2 * SW)'(sza_q) * (2 * SW)'(szb_q);
			S_RB_HD: begin
				ra_q <= hs_rdata[2*NW-1:NW];
				rb_q <= hs_rdata[NW-1:0];
			end
			S_RB_SK: sza_q <= sz_rdata;
			S_RB_SH: szb_q <= sz_rdata;
			S_DONE: begin
				if (rsp_load) begin
					rsp_q.status        <= st_q;
					rsp_q.size_product  <= prod_ext[UFR_PROD_W-1:0];
					rsp_q.history_depth <= cnt_ext[UFR_DEPTH_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	a_hist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= NODES - 1)
		else $error("history depth beyond node count");

	a_merge_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |-> mg_keep != mg_hung)
		else $error("merge of a root with itself");

	a_undo_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RB_RD |-> cnt_ext > tgt_ext && cnt_q != '0)
		else $error("undo step with nothing left to undo");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> req_stall && (!par_we || par_waddr == clr_q))
		else $error("request taken or stray write during clearing sweep");

endmodule

FILE: tb/ufr_checker.sv
// ----------------------------------------------------------------------------
// ufr_checker
// Watches both channels of the disjoint-set store and keeps its own copy of
// the parent links, set sizes and undo history. It works out the answer to
// every accepted request and compares each response beat, field by field,
// with the oldest answer still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ufr_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  ufr_pkg::ufr_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  ufr_pkg::ufr_rsp_t rsp,
	output int                fail_count,
	output int                pending_count,
	output int                peak_depth
);

	import ufr_pkg::*;

	logic [UFR_IDX_W-1:0] dsu_parent [UFR_NODES];
	logic [UFR_IDX_W:0]   dsu_size   [UFR_NODES];
	logic [UFR_IDX_W-1:0] undo_keep  [UFR_NODES];
	logic [UFR_IDX_W-1:0] undo_hung  [UFR_NODES];
	int                   undo_depth;
	ufr_rsp_t             answer_q[$];

	function automatic logic [UFR_IDX_W-1:0] find_root(input logic [UFR_IDX_W-1:0] x);
		logic [UFR_IDX_W-1:0] cur;
		cur = x;
		while (dsu_parent[cur] != cur)
			cur = dsu_parent[cur];
		return cur;
	endfunction

	task automatic dsu_apply(input ufr_req_t r, output ufr_rsp_t ans);
		logic [UFR_IDX_W-1:0] ra;
		logic [UFR_IDX_W-1:0] rb;
		logic [UFR_IDX_W-1:0] t;
		ans = '0;
		case (r.action)
			ACT_UNITE: begin
				ra = find_root(r.node_a);
				rb = find_root(r.node_b);
				if (ra == rb) begin
					ans.status = ST_SAME;
				end else begin
					// equal sizes keep node_a's root on top
					if (dsu_size[rb] > dsu_size[ra]) begin
						t  = ra;
						ra = rb;
						rb = t;
					end
					undo_keep[undo_depth] = ra;
					undo_hung[undo_depth] = rb;
					undo_depth++;
					dsu_size[ra] += dsu_size[rb];
					dsu_parent[rb] = ra;
					ans.status = ST_MERGED;
				end
			end
			ACT_ROLLBACK: begin
				if (undo_depth <= r.target_depth) begin
					ans.status = ST_NOTHING;
				end else begin
					while (undo_depth > r.target_depth) begin
						undo_depth--;
						ra = undo_keep[undo_depth];
						rb = undo_hung[undo_depth];
						dsu_size[ra] -= dsu_size[rb];
						dsu_parent[rb] = rb;
					end
					ans.status = ST_ROLLED;
				end
			end
			ACT_QUERY: begin
				ra = find_root(r.node_a);
				rb = find_root(r.node_b);
				ans.size_product = UFR_PROD_W'(dsu_size[ra]) * UFR_PROD_W'(dsu_size[rb]);
				ans.status = ST_MERGED;
			end
			default: begin
				// unused code leaves the store alone
				ans.status = ST_MERGED;
			end
		endcase
		ans.history_depth = UFR_DEPTH_W'(undo_depth);
	endtask

	always @(posedge clk or negedge arst_n) begin : dsu_watch
		ufr_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < UFR_NODES; i++) begin
				dsu_parent[i] = UFR_IDX_W'(i);
				dsu_size[i]   = 1;
			end
			undo_depth = 0;
			answer_q.delete();
			fail_count    = 0;
			pending_count = 0;
			peak_depth    = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (answer_q.size() == 0) begin
					$error("response beat with no request waiting: status %0d depth %0d",
						rsp.status, rsp.history_depth);
					fail_count++;
				end else begin
					want = answer_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.size_product !== want.size_product) begin
						$error("size_product: expected %0d, got %0d",
							want.size_product, rsp.size_product);
						fail_count++;
					end
					if (rsp.history_depth !== want.history_depth) begin
						$error("history_depth: expected %0d, got %0d",
							want.history_depth, rsp.history_depth);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				dsu_apply(req, want);
				answer_q.insert(answer_q.size(), want);
				if (undo_depth > peak_depth)
					peak_depth = undo_depth;
			end
			pending_count = answer_q.size();
		end
	end

endmodule

FILE: tb/union_find_with_rollback_tb.sv
// ----------------------------------------------------------------------------
// union_find_with_rollback_tb
// Drives unite, roll back, size product and unused requests into the store:
// a directed opening on ties, repeats, empty rollbacks and the index
// extremes, then random requests drawn from node pools of varying width so
// that sets grow deep and rollbacks undo long runs. Both channels idle at
// random; the checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module union_find_with_rollback_tb;

	import ufr_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 1330;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 40000;
	localparam int TAIL_CYCLES   = 60;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	ufr_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	ufr_rsp_t rsp;

	int fail_count;
	int pending_count;
	int peak_depth;

	bit calm;
	bit hold_off;
	int est_depth;
	int n_unite;
	int n_rollback;
	int n_query;
	int n_unused;

	union_find_with_rollback i_dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	ufr_checker i_dsu_check (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.fail_count,
		.pending_count,
		.peak_depth
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [UFR_IDX_W-1:0] any_idx();
		return UFR_IDX_W'($urandom);
	endfunction

	task automatic issue(input logic [1:0] act, input logic [UFR_IDX_W-1:0] a,
		input logic [UFR_IDX_W-1:0] b, input logic [UFR_DEPTH_W-1:0] tgt);
		ufr_req_t r;
		int gap;
		r.action       = act;
		r.node_a       = a;
		r.node_b       = b;
		r.target_depth = tgt;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
		case (act)
			ACT_UNITE: begin
				n_unite++;
				if (est_depth < UFR_NODES - 1)
					est_depth++;
			end
			ACT_ROLLBACK: begin
				n_rollback++;
				if (tgt < est_depth)
					est_depth = tgt;
			end
			ACT_QUERY: n_query++;
			default:   n_unused++;
		endcase
	endtask

	// receiver side: random stalls, plus one long hold-off on request
	initial begin : rsp_side
		int stall_left;
		stall_left = 0;
		rsp_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_off   = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int pool_base;
		int pool_span;
		int r;
		int back;
		logic [UFR_DEPTH_W-1:0] tgt;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		calm       = 1'b0;
		hold_off   = 1'b0;
		est_depth  = 0;
		n_unite    = 0;
		n_rollback = 0;
		n_query    = 0;
		n_unused   = 0;
		pool_base  = 0;
		pool_span  = UFR_NODES;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening
		issue(ACT_QUERY,    10'd0,    10'd1023, any_idx());
		issue(ACT_UNITE,    10'd0,    10'd1023, any_idx());
		issue(ACT_UNITE,    10'd1023, 10'd5,    any_idx());
		issue(ACT_UNITE,    10'd6,    10'd7,    any_idx());
		issue(ACT_UNITE,    10'd7,    10'd0,    any_idx());
		issue(ACT_UNITE,    10'd5,    10'd1023, any_idx());
		issue(ACT_QUERY,    10'd7,    10'd1023, any_idx());
		issue(ACT_QUERY,    10'd512,  10'd512,  any_idx());
		issue(ACT_ROLLBACK, any_idx(), any_idx(), 10'd1023);
		issue(ACT_ROLLBACK, any_idx(), any_idx(), 10'd4);
		issue(ACT_ROLLBACK, any_idx(), any_idx(), 10'd3);
		issue(ACT_UNUSED,   any_idx(), any_idx(), any_idx());
		issue(ACT_QUERY,    10'd0,    10'd6,    any_idx());
		issue(ACT_UNITE,    10'd682,  10'd341,  any_idx());
		issue(ACT_UNITE,    10'd341,  10'd682,  any_idx());
		issue(ACT_ROLLBACK, any_idx(), any_idx(), 10'd0);
		issue(ACT_ROLLBACK, any_idx(), any_idx(), 10'd0);
		issue(ACT_QUERY,    10'd0,    10'd1023, any_idx());
		issue(ACT_UNITE,    10'd1023, 10'd1022, any_idx());
		issue(ACT_UNITE,    10'd1021, 10'd1023, any_idx());
		issue(ACT_QUERY,    10'd1021, 10'd1022, any_idx());
		issue(ACT_UNUSED,   10'd1023, 10'd0,    10'd1023);

		// random part: all four request codes over shifting node pools
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				pool_base = $urandom_range(0, UFR_NODES - 1);
				case ($urandom_range(0, 3))
					0:       pool_span = 8;
					1:       pool_span = 64;
					2:       pool_span = 256;
					default: pool_span = UFR_NODES;
				endcase
			end
			if (i == 300)
				hold_off = 1'b1;
			if (i == 600) begin
				req_valid <= 1'b0;
				@(negedge clk);
				while (pending_count != 0)
					@(negedge clk);
			end
			calm = (i >= 800 && i < 900);

			r = $urandom_range(0, 99);
			if (r < 56) begin
				issue(ACT_UNITE,
					UFR_IDX_W'(pool_base + $urandom_range(0, pool_span - 1)),
					UFR_IDX_W'(pool_base + $urandom_range(0, pool_span - 1)),
					any_idx());
			end else if (r < 76) begin
				issue(ACT_QUERY,
					UFR_IDX_W'(pool_base + $urandom_range(0, pool_span - 1)),
					UFR_IDX_W'(pool_base + $urandom_range(0, pool_span - 1)),
					any_idx());
			end else if (r < 96) begin
				back = $urandom_range(0, 99);
				if (back < 5)
					tgt = '0;
				else if (back < 25)
					tgt = any_idx();
				else begin
					back = $urandom_range(0, 6);
					tgt  = (est_depth > back) ? UFR_DEPTH_W'(est_depth - back) : '0;
				end
				issue(ACT_ROLLBACK, any_idx(), any_idx(), tgt);
			end else begin
				issue(ACT_UNUSED, any_idx(), any_idx(), any_idx());
			end
		end
		req_valid <= 1'b0;
		calm = 1'b0;

		while (pending_count != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("ran %0d requests: %0d unite, %0d rollback, %0d query, %0d unused code",
			n_unite + n_rollback + n_query + n_unused, n_unite, n_rollback, n_query, n_unused);
		$display("undo history peaked at depth %0d, %0d mismatches seen",
			peak_depth, fail_count);
		if (fail_count == 0 && pending_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
